/* rtl/rsd_pkg.sv */
// Shared types and constants for the descending record sorter.
package rsd_pkg;

    localparam int ENTRIES = 16;
    localparam int STAGES  = 5;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 24;
    localparam int ID_W    = 16;
    localparam int SCORE_W = 16;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [KEY_W-1:0]   total_key;
        logic [ID_W-1:0]    player_id;
        logic [SCORE_W-1:0] stage_a;
        logic [SCORE_W-1:0] stage_b;
        logic [SCORE_W-1:0] stage_c;
        logic [SCORE_W-1:0] stage_d;
        logic [SCORE_W-1:0] stage_e;
        logic               last_in;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]   sorted_key;
        logic [ID_W-1:0]    sorted_id;
        logic [SCORE_W-1:0] out_a;
        logic [SCORE_W-1:0] out_b;
        logic [SCORE_W-1:0] out_c;
        logic [SCORE_W-1:0] out_d;
        logic [SCORE_W-1:0] out_e;
        logic               overflow;
        logic               last_out;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]                  key;
        logic [ID_W-1:0]                   id;
        logic [STAGES-1:0][SCORE_W-1:0]    stage;
    } rec_t;

endpackage

/* rtl/record_sort_by_score_desc.sv */
// Top level of the stable descending record sorter.
//
// Records are handed in one per transfer: a transfer happens at each rising
// edge where start is high and busy is low. A four-entry queue sits in front
// of the sorter, so start may be held high every cycle; busy rises only when
// that queue is full. The sorter drains the queue at one record per cycle
// while it is not shifting results out, dropping each record into its place
// in a chain of ENTRIES cells (equal keys go behind earlier ones, so arrival
// order is kept). The record with last_in set closes the set: in the cycle
// after it is inserted, the sorter starts shifting the kept records out of
// the chain head at one per cycle, largest key first, and each one is
// registered and shows on result in the cycle after it leaves the head, for
// exactly one cycle with result_valid high. While a set is shifted out the
// sorter takes no records; the queue keeps taking up to four records of the
// next set meanwhile. The receiver cannot stall the output, so it must
// take every result in its cycle. Records past ENTRIES in one set are
// dropped; overflow is then high on every result of that set, and last_out
// marks the final result.
module record_sort_by_score_desc
    import rsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      result_valid,
    output out_item_t result
);

    logic     q_valid;
    logic     q_pop;
    in_item_t q_item;

    // Hold incoming records until the sorter is free to take them.
    rsd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .busy    (busy),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    // Insert records in key order, then stream the set out on the closing record.
    rsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* rtl/rsd_front.sv */
// Front end: accepts records and buffers them in a short queue for the sorter.
module rsd_front
    import rsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  in_item_t item,
    output logic     busy,
    output logic     q_valid,
    output in_item_t q_item,
    input  logic     q_pop
);

    in_item_t             mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                 push;
    logic                 pop;

    assign busy    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem[rd_ptr_reg];
    assign push    = start && !busy;
    assign pop     = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("sorter popped an empty queue");

endmodule

/* rtl/rsd_back.sv */
// Back end: insertion chain that keeps records sorted, then shifts them out.
module rsd_back
    import rsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  in_item_t  q_item,
    output logic      q_pop,
    output logic      result_valid,
    output out_item_t result
);

    rec_t               cell_reg [ENTRIES];
    rec_t               cell_next [ENTRIES];
    rec_t               new_rec;
    logic [ENTRIES-1:0] ge;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dropped_reg, dropped_next;
    logic               emit_reg, emit_next;
    logic               valid_reg, valid_next;
    out_item_t          result_reg, result_next;
    logic               full;
    logic               do_ins;

    assign q_pop        = q_valid && !emit_reg;
    assign full         = (count_reg == CNT_W'(ENTRIES));
    assign do_ins       = q_pop && !full;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        new_rec.key      = q_item.total_key;
        new_rec.id       = q_item.player_id;
        new_rec.stage[0] = q_item.stage_a;
        new_rec.stage[1] = q_item.stage_b;
        new_rec.stage[2] = q_item.stage_c;
        new_rec.stage[3] = q_item.stage_d;
        new_rec.stage[4] = q_item.stage_e;
    end

    // ge is a prefix: cells holding keys not below the new one stay put.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            ge[i] = (CNT_W'(i) < count_reg) && (cell_reg[i].key >= new_rec.key);
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (emit_reg)
            begin
                if (i < ENTRIES - 1)
                begin
                    cell_next[i] = cell_reg[(i + 1) % ENTRIES];
                end
            end
            else if (do_ins)
            begin
                if (i == 0)
                begin
                    if (!ge[0])
                    begin
                        cell_next[i] = new_rec;
                    end
                end
                else if (!ge[i])
                begin
                    cell_next[i] = ge[(i + ENTRIES - 1) % ENTRIES] ? new_rec
                                 : cell_reg[(i + ENTRIES - 1) % ENTRIES];
                end
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        emit_next    = emit_reg;
        valid_next   = 1'b0;
        result_next  = result_reg;
        if (emit_reg)
        begin
            valid_next             = 1'b1;
            result_next.sorted_key = cell_reg[0].key;
            result_next.sorted_id  = cell_reg[0].id;
            result_next.out_a      = cell_reg[0].stage[0];
            result_next.out_b      = cell_reg[0].stage[1];
            result_next.out_c      = cell_reg[0].stage[2];
            result_next.out_d      = cell_reg[0].stage[3];
            result_next.out_e      = cell_reg[0].stage[4];
            result_next.overflow   = dropped_reg;
            result_next.last_out   = (count_reg == CNT_W'(1));
            count_next             = count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                emit_next    = 1'b0;
                dropped_next = 1'b0;
            end
        end
        else if (q_pop)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
            if (q_item.last_in)
            begin
                emit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            emit_reg    <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            emit_reg    <= emit_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        for (int i = 0; i < ENTRIES; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond capacity");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg |-> (count_reg != '0))
        else $error("emitting from an empty store");

    a_last_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_reg.last_out) |=> !valid_reg)
        else $error("results continue past the last of the set");

    a_last_once: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_reg && count_reg != CNT_W'(1)) |=> (valid_reg && !result_reg.last_out))
        else $error("last flag on an inner result");

endmodule

/* test/record_sort_by_score_desc_tb.sv */
// Self-checking testbench for the stable descending record sorter.
`timescale 1ns / 1ps

module record_sort_by_score_desc_tb
    import rsd_pkg::*;
();

    // One row of the directed plan. When pinned is set, want is the literal
    // result of a one-record set and replaces the ranked prediction.
    typedef struct {
        in_item_t  rec;
        bit        pinned;
        out_item_t want;
    } stim_row_t;

    typedef struct {
        bit        on;
        out_item_t val;
    } pin_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    in_item_t  item;
    logic      busy;
    logic      result_valid;
    out_item_t result;

    // Own copy of the sorter: the kept records of the open set, best first.
    in_item_t  ranked [ENTRIES];
    int        held;
    bit        spilled;

    out_item_t sorted_expect [$];   // results still owed by the block, in order
    pin_t      pinned_q [$];        // one entry per driven transfer

    int        errors;
    int        items_sent;
    int        sets_closed;
    int        overflow_sets;
    int        results_seen;
    int        calm_left;           // transfers left in a no-idle stretch

    record_sort_by_score_desc dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs or never drains its results.
    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic in_item_t mk_item(input logic [KEY_W-1:0] key,
                                         input logic [ID_W-1:0] id,
                                         input logic [SCORE_W-1:0] a, b, c, d, e,
                                         input logic last);
        in_item_t r;
        r = '{total_key: key, player_id: id, stage_a: a, stage_b: b, stage_c: c,
              stage_d: d, stage_e: e, last_in: last};
        return r;
    endfunction

    function automatic out_item_t mk_result(input logic [KEY_W-1:0] key,
                                            input logic [ID_W-1:0] id,
                                            input logic [SCORE_W-1:0] a, b, c, d, e,
                                            input logic ovf, last);
        out_item_t r;
        r = '{sorted_key: key, sorted_id: id, out_a: a, out_b: b, out_c: c,
              out_d: d, out_e: e, overflow: ovf, last_out: last};
        return r;
    endfunction

    // Insert one record the way the sorter does: behind every equal key, so
    // arrival order survives among ties. Drop it when the store is full. On
    // the closing record, queue the whole ranked set and clear for the next.
    function automatic void rank_record(input in_item_t rec);
        int pos;
        if (held < ENTRIES)
        begin
            pos = 0;
            while (pos < held && ranked[pos].total_key >= rec.total_key)
                pos++;
            for (int i = held; i > pos; i--)
                ranked[i] = ranked[i-1];
            ranked[pos] = rec;
            held++;
        end
        else
        begin
            spilled = 1'b1;
        end
        if (rec.last_in)
        begin
            for (int k = 0; k < held; k++)
                sorted_expect.push_back(mk_result(ranked[k].total_key,
                    ranked[k].player_id, ranked[k].stage_a, ranked[k].stage_b,
                    ranked[k].stage_c, ranked[k].stage_d, ranked[k].stage_e,
                    spilled, k == held - 1));
            sets_closed++;
            if (spilled)
                overflow_sets++;
            held    = 0;
            spilled = 1'b0;
        end
    endfunction

    function automatic void check_result(input out_item_t want, input out_item_t got);
        if (got.sorted_key !== want.sorted_key)
        begin
            $error("sorted_key: expected %h, got %h", want.sorted_key, got.sorted_key);
            errors++;
        end
        if (got.sorted_id !== want.sorted_id)
        begin
            $error("sorted_id: expected %h, got %h", want.sorted_id, got.sorted_id);
            errors++;
        end
        if (got.out_a !== want.out_a)
        begin
            $error("out_a: expected %h, got %h", want.out_a, got.out_a);
            errors++;
        end
        if (got.out_b !== want.out_b)
        begin
            $error("out_b: expected %h, got %h", want.out_b, got.out_b);
            errors++;
        end
        if (got.out_c !== want.out_c)
        begin
            $error("out_c: expected %h, got %h", want.out_c, got.out_c);
            errors++;
        end
        if (got.out_d !== want.out_d)
        begin
            $error("out_d: expected %h, got %h", want.out_d, got.out_d);
            errors++;
        end
        if (got.out_e !== want.out_e)
        begin
            $error("out_e: expected %h, got %h", want.out_e, got.out_e);
            errors++;
        end
        if (got.overflow !== want.overflow)
        begin
            $error("overflow: expected %b, got %b", want.overflow, got.overflow);
            errors++;
        end
        if (got.last_out !== want.last_out)
        begin
            $error("last_out: expected %b, got %b", want.last_out, got.last_out);
            errors++;
        end
    endfunction

    // Sample at the edge: a transfer in happens where start is high and busy
    // low; a result is taken in the one cycle its strobe is high.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            pin_t pin;
            pin = '{on: 1'b0, val: '0};
            if (pinned_q.size() > 0)
                pin = pinned_q.pop_front();
            rank_record(item);
            // Pinned rows are one-record sets: swap in the typed result.
            if (pin.on)
                sorted_expect[$] = pin.val;
        end
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (sorted_expect.size() == 0)
            begin
                $error("unexpected result: key %h id %h", result.sorted_key,
                       result.sorted_id);
                errors++;
            end
            else
            begin
                check_result(sorted_expect.pop_front(), result);
            end
        end
    end

    // Idle length before the next transfer: mostly none or short, a few long,
    // and now and then a run of transfers with no idling at all.
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm_left = $urandom_range(8, 30);
        if (r < 45)
            return 0;
        if (r < 82)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Hold the record on item with start high until the block takes it.
    task automatic send_record(input in_item_t rec, input bit pinned, input out_item_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pinned_q.push_back('{on: pinned, val: want});
        start <= 1'b1;
        item  <= rec;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    // Key styles: wide random keys, a tiny range to force ties, or extremes.
    function automatic in_item_t rand_record(input int key_mode, input bit last);
        logic [KEY_W-1:0] key;
        case (key_mode)
            0: key = KEY_W'($urandom);
            1: key = KEY_W'($urandom_range(0, 3));
            default:
            begin
                case ($urandom_range(0, 2))
                    0: key = '0;
                    1: key = '1;
                    default: key = {1'b1, {(KEY_W-1){1'b0}}};
                endcase
            end
        endcase
        return mk_item(key, ID_W'($urandom), SCORE_W'($urandom), SCORE_W'($urandom),
                       SCORE_W'($urandom), SCORE_W'($urandom), SCORE_W'($urandom), last);
    endfunction

    initial
    begin
        stim_row_t plan [$];
        int        set_len;
        int        key_mode;
        int        r;

        rst_n         = 1'b0;
        start         = 1'b0;
        item          = '0;
        held          = 0;
        spilled       = 1'b0;
        errors        = 0;
        items_sent    = 0;
        sets_closed   = 0;
        overflow_sets = 0;
        results_seen  = 0;
        calm_left     = 0;

        // One-record sets right after reset: all ones, all zeros, a checker
        // pattern. The result is the record itself, closing, no overflow.
        plan.push_back('{mk_item('1, '1, '1, '1, '1, '1, '1, 1'b1), 1'b1,
            mk_result(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 1'b0, 1'b1)});
        plan.push_back('{mk_item('0, '0, '0, '0, '0, '0, '0, 1'b1), 1'b1,
            mk_result(24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000, 1'b0, 1'b1)});
        plan.push_back('{mk_item(24'h555555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                 16'hAAAA, 16'h5555, 1'b1), 1'b1,
            mk_result(24'h555555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                      16'hAAAA, 16'h5555, 1'b0, 1'b1)});
        // Ties: equal keys must come back in arrival order.
        plan.push_back('{mk_item(24'd5, 16'd1, 16'd11, 16'd12, 16'd13, 16'd14, 16'd15, 1'b0),
                         1'b0, '0});
        plan.push_back('{mk_item(24'd9, 16'd2, 16'd21, 16'd22, 16'd23, 16'd24, 16'd25, 1'b0),
                         1'b0, '0});
        plan.push_back('{mk_item(24'd5, 16'd3, 16'd31, 16'd32, 16'd33, 16'd34, 16'd35, 1'b0),
                         1'b0, '0});
        plan.push_back('{mk_item(24'd9, 16'd4, 16'd41, 16'd42, 16'd43, 16'd44, 16'd45, 1'b1),
                         1'b0, '0});
        // Full store: eighteen records, so the last two are dropped, the
        // closing one among them, and overflow rides on every result.
        for (int i = 0; i < 18; i++)
            plan.push_back('{mk_item(KEY_W'((i % 4) * 'h100), ID_W'('h100 + i),
                                     SCORE_W'(i * 'h1111), SCORE_W'(i), SCORE_W'(i + 1),
                                     SCORE_W'(i + 2), SCORE_W'(~i), i == 17),
                             1'b0, '0});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[n])
            send_record(plan[n].rec, plan[n].pinned, plan[n].want);

        // Random sets: mostly short, some exactly full, some overfull.
        while (items_sent < 226)
        begin
            r = $urandom_range(0, 9);
            if (r <= 5)
                set_len = $urandom_range(1, 6);
            else if (r == 6)
                set_len = ENTRIES;
            else if (r == 7)
                set_len = $urandom_range(ENTRIES + 1, ENTRIES + 4);
            else
                set_len = $urandom_range(1, ENTRIES);
            key_mode = $urandom_range(0, 2);
            for (int k = 0; k < set_len; k++)
                send_record(rand_record(key_mode, k == set_len - 1), 1'b0, '0);
        end

        start <= 1'b0;
        @(posedge clk);
        while (sorted_expect.size() > 0)
            @(posedge clk);
        // Watch a while longer for stray results.
        repeat (40) @(posedge clk);

        $display("Sent %0d records in %0d sets (%0d overflowed), checked %0d results.",
                 items_sent, sets_closed, overflow_sets, results_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
